[design/ssw_pkg.sv]
// Shared types and constants for the sliding-window transmit block.
// No dependencies; used by every module of the block.
package ssw_pkg;

	localparam int RING_DEPTH = 16;
	localparam int PTR_W      = $clog2(RING_DEPTH);
	localparam int CNT_W      = $clog2(RING_DEPTH + 1);
	localparam int WINDOW_CAP = 16;
	localparam int WIN_W      = 5;
	localparam int QDEPTH     = 2;

	localparam logic [1:0] OP_ENQ    = 2'd0;
	localparam logic [1:0] OP_ACK    = 2'd1;
	localparam logic [1:0] OP_COMMIT = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [1:0] KIND_SYN    = 2'd1;
	localparam logic [1:0] KIND_SYNACK = 2'd2;

	localparam logic [2:0] RK_SEND     = 3'd0;
	localparam logic [2:0] RK_ACK_OK   = 3'd1;
	localparam logic [2:0] RK_ACK_MISS = 3'd2;
	localparam logic [2:0] RK_ENQ      = 3'd3;
	localparam logic [2:0] RK_FULL     = 3'd4;
	localparam logic [2:0] RK_COMMIT   = 3'd5;

	localparam logic [0:0] REG_WINDOW_LIMIT = 1'd0;
	localparam logic [0:0] REG_AUTO_SEND    = 1'd1;

	// command handed from front to back
	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] seq;
		logic [31:0] ack;
		logic [15:0] len;
		logic [1:0]  kind;
		logic        want;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ENQ,
		ST_SCAN,
		ST_SLIDE,
		ST_COMMIT,
		ST_STATUS
	} state_t;

	// expected acknowledge of a stored entry
	function automatic logic [31:0] expect_ack(input logic [31:0] seq,
	                                           input logic [15:0] len);
		logic [31:0] inc;
		inc = (len == 16'd0) ? 32'd1 : {16'd0, len};
		return seq + inc;
	endfunction

endpackage

[design/send_sliding_window.sv]
// A command may wait in the front queue before its back-end run; an ack scans
// the window one entry a cycle, a slide pops one head entry a cycle, and a
// commit walks the window one entry a cycle, first fixing its size.
// Throughput: one command per its back-end run; a two-entry queue holds
// commands behind it. Reset clears pointers, counts and flags; ring payload
// is not cleared. Results cannot be stalled by the receiver.
// Top level: configuration registers, front queue and back sequencer.
// Depends on ssw_pkg, ssw_front, ssw_back.
module send_sliding_window (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [31:0] seq_num,
	input  logic [31:0] ack_num,
	input  logic [15:0] payload_len,
	input  logic [1:0]  pkt_kind,
	input  logic        wants_ack,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [4:0]  cfg_data,
	output logic        strobe,
	output logic [2:0]  result_kind,
	output logic [3:0]  slot,
	output logic [31:0] out_seq,
	output logic [31:0] out_ack,
	output logic [15:0] out_len,
	output logic [4:0]  in_window,
	output logic        last
);

	logic [4:0]    limit_q;
	logic          auto_q;
	logic          cmd_valid, cmd_take;
	ssw_pkg::cmd_t cmd;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= 5'd16;
			auto_q  <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ssw_pkg::REG_WINDOW_LIMIT: limit_q <= cfg_data;
				default:                   auto_q  <= cfg_data[0];
			endcase
		end
	end

	ssw_front u_front (
		.clk, .arst_n, .start, .busy, .opcode, .seq_num, .ack_num, .payload_len,
		.pkt_kind, .wants_ack, .cmd_valid, .cmd, .cmd_take
	);

	ssw_back u_back (
		.clk, .arst_n, .cmd_valid, .cmd, .cmd_take,
		.window_limit(limit_q), .auto_send(auto_q),
		.res_valid(strobe), .result_kind, .slot, .out_seq, .out_ack, .out_len,
		.in_window, .last
	);

endmodule

[design/ssw_front.sv]
// Front part: accepts commands, drops unused opcodes, queues the rest.
// Depends on ssw_pkg.
module ssw_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  logic [1:0]      opcode,
	input  logic [31:0]     seq_num,
	input  logic [31:0]     ack_num,
	input  logic [15:0]     payload_len,
	input  logic [1:0]      pkt_kind,
	input  logic            wants_ack,
	output logic            cmd_valid,
	output ssw_pkg::cmd_t   cmd,
	input  logic            cmd_take
);

	localparam int QP_W = $clog2(ssw_pkg::QDEPTH);

	ssw_pkg::cmd_t     fifo_q [ssw_pkg::QDEPTH];
	logic [QP_W-1:0]   wr_q, rd_q;
	logic [QP_W:0]     cnt_q;
	logic              push, pop;

	assign busy      = (cnt_q == (QP_W+1)'(ssw_pkg::QDEPTH));
	// the unused opcode leaves no trace
	assign push      = start && !busy && (opcode != ssw_pkg::OP_UNUSED);
	assign cmd_valid = (cnt_q != '0);
	assign pop       = cmd_valid && cmd_take;
	assign cmd       = fifo_q[rd_q];

	// store payload
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= '{op: opcode, seq: seq_num, ack: ack_num,
			                  len: payload_len, kind: pkt_kind, want: wants_ack};
		end
	end

	// advance pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (QP_W+1)'(push) - (QP_W+1)'(pop);
		end
	end

endmodule

[design/ssw_back.sv]
// Back part: ring of descriptors, window scan, slide and commit sequencer.
// Depends on ssw_pkg.
module ssw_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	input  ssw_pkg::cmd_t        cmd,
	output logic                 cmd_take,
	input  logic [4:0]           window_limit,
	input  logic                 auto_send,
	output logic                 res_valid,
	output logic [2:0]           result_kind,
	output logic [3:0]           slot,
	output logic [31:0]          out_seq,
	output logic [31:0]          out_ack,
	output logic [15:0]          out_len,
	output logic [4:0]           in_window,
	output logic                 last
);

	localparam int PW = ssw_pkg::PTR_W;
	localparam int CW = ssw_pkg::CNT_W;
	localparam int WW = ssw_pkg::WIN_W;

	logic [31:0] mem_seq [ssw_pkg::RING_DEPTH];
	logic [31:0] mem_ack [ssw_pkg::RING_DEPTH];
	logic [15:0] mem_len [ssw_pkg::RING_DEPTH];
	logic [ssw_pkg::RING_DEPTH-1:0] syn_q, need_q, sent_q;

	ssw_pkg::state_t state_q, state_d;
	ssw_pkg::cmd_t   c_q;
	logic [PW-1:0]   head_q;
	logic [CW-1:0]   qcnt_q;
	logic [WW-1:0]   win_q;
	logic [WW-1:0]   idx_q;
	logic [WW-1:0]   wtarget_q;
	logic [2:0]      status_q;

	logic [PW-1:0]   cur;
	logic [PW-1:0]   tail;
	logic [31:0]     r_seq, r_ack;
	logic [15:0]     r_len;
	logic            hit;
	logic [CW-1:0]   wcalc;

	assign cur  = head_q + idx_q[PW-1:0];
	assign tail = head_q + qcnt_q[PW-1:0];
	assign r_seq = mem_seq[cur];
	assign r_ack = mem_ack[cur];
	assign r_len = mem_len[cur];

	// ack match for the entry under the scan pointer
	always_comb begin
		logic eq;
		eq  = (c_q.ack == ssw_pkg::expect_ack(r_seq, r_len));
		hit = need_q[cur] && eq &&
		      ((syn_q[cur] && c_q.kind == ssw_pkg::KIND_SYNACK) || c_q.seq == r_ack);
	end

	// window size for a commit: min(limit, count, cap)
	always_comb begin
		logic [CW:0] m;
		m = ({1'b0, CW'(window_limit)} < {1'b0, qcnt_q}) ?
		    (CW+1)'(window_limit) : {1'b0, qcnt_q};
		if (m > (CW+1)'(ssw_pkg::WINDOW_CAP)) m = (CW+1)'(ssw_pkg::WINDOW_CAP);
		wcalc = m[CW-1:0];
	end

	assign cmd_take = (state_q == ssw_pkg::ST_IDLE) && cmd_valid;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ssw_pkg::ST_IDLE:   if (cmd_valid) begin
				unique case (cmd.op)
					ssw_pkg::OP_ENQ: state_d = ssw_pkg::ST_ENQ;
					ssw_pkg::OP_ACK: state_d = ssw_pkg::ST_SCAN;
					default:         state_d = ssw_pkg::ST_COMMIT;
				endcase
			end
			ssw_pkg::ST_ENQ:    state_d = (qcnt_q >= CW'(ssw_pkg::RING_DEPTH) || !auto_send) ?
			                             ssw_pkg::ST_STATUS : ssw_pkg::ST_COMMIT;
			ssw_pkg::ST_SCAN: begin
				if (win_q == '0 || qcnt_q == '0 || idx_q >= win_q ||
				    CW'(idx_q) >= qcnt_q) state_d = ssw_pkg::ST_STATUS;
				else if (hit) state_d = (idx_q == '0) ? ssw_pkg::ST_SLIDE
				                                      : ssw_pkg::ST_STATUS;
			end
			ssw_pkg::ST_SLIDE:  if (qcnt_q == '0 || need_q[head_q] || !sent_q[head_q])
				state_d = ssw_pkg::ST_COMMIT;
			ssw_pkg::ST_COMMIT: if (idx_q != '0 && idx_q >= wtarget_q)
				state_d = ssw_pkg::ST_STATUS;
			ssw_pkg::ST_STATUS: state_d = ssw_pkg::ST_IDLE;
			default:            state_d = ssw_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ssw_pkg::ST_IDLE;
		else         state_q <= state_d;
	end

	// ring payload writes
	always_ff @(posedge clk) begin
		if (state_q == ssw_pkg::ST_ENQ && qcnt_q < CW'(ssw_pkg::RING_DEPTH)) begin
			mem_seq[tail] <= c_q.seq;
			mem_ack[tail] <= c_q.ack;
			mem_len[tail] <= c_q.len;
		end
		if (cmd_take) c_q <= cmd;
	end

	// control state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0; qcnt_q <= '0; win_q <= '0; idx_q <= '0; wtarget_q <= '0;
			status_q <= ssw_pkg::RK_COMMIT;
			syn_q <= '0; need_q <= '0; sent_q <= '0;
			res_valid <= 1'b0; result_kind <= '0; slot <= '0; out_seq <= '0;
			out_ack <= '0; out_len <= '0; in_window <= '0; last <= 1'b0;
		end else begin
			res_valid <= 1'b0;
			unique case (state_q)
				ssw_pkg::ST_IDLE: begin
					idx_q <= '0;
					status_q <= (cmd.op == ssw_pkg::OP_ACK) ? ssw_pkg::RK_ACK_MISS :
					            (cmd.op == ssw_pkg::OP_ENQ) ? ssw_pkg::RK_ENQ :
					            ssw_pkg::RK_COMMIT;
				end
				ssw_pkg::ST_ENQ: begin
					if (qcnt_q >= CW'(ssw_pkg::RING_DEPTH)) status_q <= ssw_pkg::RK_FULL;
					else begin
						syn_q[tail]  <= (c_q.kind == ssw_pkg::KIND_SYN);
						need_q[tail] <= c_q.want;
						sent_q[tail] <= 1'b0;
						qcnt_q <= qcnt_q + 1'b1;
					end
				end
				ssw_pkg::ST_SCAN: begin
					if (!(win_q == '0 || qcnt_q == '0 || idx_q >= win_q ||
					      CW'(idx_q) >= qcnt_q)) begin
						if (hit) begin
							need_q[cur] <= 1'b0;
							status_q <= ssw_pkg::RK_ACK_OK;
							idx_q <= '0;
						end else idx_q <= idx_q + 1'b1;
					end
				end
				ssw_pkg::ST_SLIDE: begin
					// pop released, sent head entries one a cycle
					if (!(qcnt_q == '0 || need_q[head_q] || !sent_q[head_q])) begin
						head_q <= head_q + 1'b1;
						qcnt_q <= qcnt_q - 1'b1;
						if (win_q != '0) win_q <= win_q - 1'b1;
					end
				end
				ssw_pkg::ST_COMMIT: begin
					// first cycle fixes the window, later ones walk it
					if (idx_q == '0) begin
						wtarget_q <= WW'(wcalc);
						win_q     <= WW'(wcalc);
						idx_q     <= WW'(1);
					end else if (idx_q < wtarget_q + 1'b1) begin
						idx_q <= idx_q + 1'b1;
					end
					if (idx_q != '0 && idx_q <= wtarget_q) begin
						if (!sent_q[head_q + PW'(idx_q - 1'b1)]) begin
							sent_q[head_q + PW'(idx_q - 1'b1)] <= 1'b1;
							res_valid   <= 1'b1;
							result_kind <= ssw_pkg::RK_SEND;
							slot        <= 4'(head_q + PW'(idx_q - 1'b1));
							out_seq     <= mem_seq[head_q + PW'(idx_q - 1'b1)];
							out_ack     <= mem_ack[head_q + PW'(idx_q - 1'b1)];
							out_len     <= mem_len[head_q + PW'(idx_q - 1'b1)];
							in_window   <= win_q;
							last        <= 1'b0;
						end
					end
				end
				ssw_pkg::ST_STATUS: begin
					res_valid   <= 1'b1;
					result_kind <= status_q;
					slot <= '0; out_seq <= '0; out_ack <= '0; out_len <= '0;
					in_window   <= win_q;
					last        <= 1'b1;
				end
				default: ;
			endcase
		end
	end

endmodule

[design/ssw_checker.sv]
// Port-level checks for the sliding-window transmit block, bound to the top.
// Depends on the top level's ports and the result codes of ssw_pkg.
module ssw_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       strobe,
	input logic [2:0] result_kind,
	input logic [3:0] slot,
	input logic [4:0] in_window,
	input logic       last
);

	// a send never claims to be last
	a_send_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result_kind == ssw_pkg::RK_SEND |-> !last) else $error("send marked last");

	// status results carry last
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result_kind != ssw_pkg::RK_SEND |-> last) else $error("status not last");

	// window never above cap
	a_win_cap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> in_window <= 5'(ssw_pkg::WINDOW_CAP)) else $error("window over cap");

	// a send lies inside a nonempty window
	a_send_win: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result_kind == ssw_pkg::RK_SEND |-> in_window != 5'd0)
		else $error("send with empty window");

	// status zeroes the slot
	a_status_slot: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |-> slot == 4'd0) else $error("status slot nonzero");

endmodule

bind send_sliding_window ssw_checker u_ssw_checker (
	.clk, .arst_n, .strobe, .result_kind, .slot, .in_window, .last
);
